/* rtl/assert_macros.svh */
// ----------------------------------------------------------------------------
// Assertion macros
// Shared concurrent assertion forms. Each expects clk and rst in scope.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled while reset is high.
`define HTA_ASSERT_IMPL(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, disabled while reset is high.
`define HTA_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

/* rtl/htally_pkg.sv */
// ----------------------------------------------------------------------------
// htally_pkg
// Types, operation codes and command/status bundles of the tally accumulator.
// ----------------------------------------------------------------------------
package htally_pkg;

  localparam logic [2:0] OP_COUNT_DET = 3'd0;
  localparam logic [2:0] OP_COUNT_SRC = 3'd1;
  localparam logic [2:0] OP_FLUSH     = 3'd2;
  localparam logic [2:0] OP_READ_DET  = 3'd3;
  localparam logic [2:0] OP_READ_SRC  = 3'd4;

  localparam logic [47:0] HIST_MAX = 48'hFFFF_FFFF_FFFF;

  typedef enum logic [1:0] {
    KIND_NONE,
    KIND_COUNT,
    KIND_FLUSH,
    KIND_READ
  } kind_t;

  // One tally bin as stored in a bank memory.
  typedef struct packed {
    logic        sat;
    logic [47:0] mark;
    logic [39:0] pending;
    logic [63:0] squares;
    logic [47:0] total;
  } entry_t;

  // Controller to datapath.
  typedef struct packed {
    logic capture;
    logic clr;
    logic rd;
    logic eval;
    logic wr;
    logic load_out;
    logic walk_inc;
    logic walk_zero;
  } ctrl_cmd_t;

  // Datapath to controller.
  typedef struct packed {
    kind_t kind;
    logic  bin_ok;
    logic  walk_last;
    logic  out_free;
  } ctrl_sts_t;

  // Datapath to one bank.
  typedef struct packed {
    logic        rd;
    logic        eval;
    logic        wr;
    logic        clr;
    logic        flush;
    logic [47:0] history;
    logic [23:0] weight;
  } bank_cmd_t;

endpackage

/* rtl/htally_bank.sv */
// ----------------------------------------------------------------------------
// htally_bank
// One tally set: bin memory plus the read-evaluate-write update of one bin.
// ----------------------------------------------------------------------------
module htally_bank #(
  parameter int DEPTH = 16384,
  parameter int AW    = 14
) (
  input  logic                  clk,
  input  htally_pkg::bank_cmd_t cmd,
  input  logic [AW-1:0]         addr,
  output htally_pkg::entry_t    rdata
);

  htally_pkg::entry_t mem [DEPTH];

  // Evaluate stage results.
  htally_pkg::entry_t ent;
  logic               fold;
  logic [63:0]        sq;
  logic               big;
  logic [47:0]        tot_new;
  logic               tot_sat;
  logic [39:0]        pend_new;
  logic               pend_sat;
  logic [47:0]        mark_new;

  logic        new_hist;
  logic        fold_c;
  logic [48:0] tot_sum;
  logic [40:0] pend_sum;
  logic [64:0] sq_sum;
  logic        sq_sat;
  htally_pkg::entry_t wdata;

  always_comb begin
    new_hist = (cmd.history >= rdata.mark) && (cmd.history != '0);
    fold_c   = cmd.flush ? (rdata.mark != '0) : new_hist;
    tot_sum  = {1'b0, rdata.total} + 49'(rdata.pending);
    pend_sum = {1'b0, rdata.pending} + 41'(cmd.weight);
  end

  always_ff @(posedge clk) begin
    if (cmd.eval) begin
      ent     <= rdata;
      fold    <= fold_c;
      sq      <= 64'(rdata.pending[31:0]) * 64'(rdata.pending[31:0]);
      big     <= |rdata.pending[39:32];
      tot_new <= tot_sum[48] ? '1 : tot_sum[47:0];
      tot_sat <= tot_sum[48];
      if (cmd.flush) begin
        pend_new <= fold_c ? '0 : rdata.pending;
        mark_new <= fold_c ? '0 : rdata.mark;
        pend_sat <= 1'b0;
      end else if (new_hist) begin
        pend_new <= 40'(cmd.weight);
        mark_new <= (cmd.history == htally_pkg::HIST_MAX) ? htally_pkg::HIST_MAX
                                                          : cmd.history + 48'd1;
        pend_sat <= 1'b0;
      end else begin
        pend_new <= pend_sum[40] ? '1 : pend_sum[39:0];
        mark_new <= rdata.mark;
        pend_sat <= pend_sum[40];
      end
    end
  end

  // A pending sum of 2^32 or more saturates the squares outright.
  always_comb begin
    sq_sum = {1'b0, ent.squares} + {1'b0, sq};
    sq_sat = big || sq_sum[64];
    if (cmd.clr) begin
      wdata = '0;
    end else begin
      wdata.total   = fold ? tot_new : ent.total;
      wdata.squares = fold ? (sq_sat ? '1 : sq_sum[63:0]) : ent.squares;
      wdata.pending = pend_new;
      wdata.mark    = mark_new;
      wdata.sat     = ent.sat | pend_sat | (fold & (tot_sat | sq_sat));
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.wr || cmd.clr) begin
      mem[addr] <= wdata;
    end
    if (cmd.rd) begin
      rdata <= mem[addr];
    end
  end

endmodule

/* rtl/htally_dp.sv */
// ----------------------------------------------------------------------------
// htally_dp
// Datapath: item capture, bin address, walk counter, both banks, result register.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module htally_dp #(
  parameter int NUM_PROJECTIONS = 64,
  parameter int NUM_PIXELS      = 256,
  parameter int DEPTH           = 16384,
  parameter int AW              = 14
) (
  input  logic                  clk,
  input  logic                  rst,
  input  htally_pkg::ctrl_cmd_t cmd,
  output htally_pkg::ctrl_sts_t sts,
  input  logic [87:0]           s_tdata,
  input  logic [2:0]            s_tuser,
  output logic                  m_tvalid,
  input  logic                  m_tready,
  output logic [111:0]          m_tdata,
  output logic [0:0]            m_tuser
);

  logic [5:0]  in_proj;
  logic [7:0]  in_pix;
  logic [31:0] bin_wide;
  logic        bin_ok_c;
  htally_pkg::kind_t kind_c;

  htally_pkg::kind_t kind;
  logic              sel_src;
  logic              bin_ok;
  logic [AW-1:0]     bin;
  logic [47:0]       history;
  logic [23:0]       weight;
  logic [AW-1:0]     walk;

  logic [47:0] res_total;
  logic [63:0] res_squares;
  logic        res_sat;

  htally_pkg::bank_cmd_t det_cmd;
  htally_pkg::bank_cmd_t src_cmd;
  htally_pkg::entry_t    det_rdata;
  htally_pkg::entry_t    src_rdata;
  logic [AW-1:0]         bank_addr;
  logic                  is_flush;

  assign in_proj  = s_tdata[5:0];
  assign in_pix   = s_tdata[13:6];
  assign bin_ok_c = ({26'd0, in_proj} < 32'(NUM_PROJECTIONS)) &&
                    ({24'd0, in_pix} < 32'(NUM_PIXELS));
  assign bin_wide = {24'd0, in_pix} + {26'd0, in_proj} * 32'(NUM_PIXELS);

  always_comb begin
    unique case (s_tuser)
      htally_pkg::OP_COUNT_DET, htally_pkg::OP_COUNT_SRC: kind_c = htally_pkg::KIND_COUNT;
      htally_pkg::OP_FLUSH:                               kind_c = htally_pkg::KIND_FLUSH;
      htally_pkg::OP_READ_DET, htally_pkg::OP_READ_SRC:   kind_c = htally_pkg::KIND_READ;
      default:                                            kind_c = htally_pkg::KIND_NONE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      kind <= htally_pkg::KIND_NONE;
    end else if (cmd.capture) begin
      kind <= kind_c;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      sel_src <= (s_tuser == htally_pkg::OP_COUNT_SRC) || (s_tuser == htally_pkg::OP_READ_SRC);
      bin_ok  <= bin_ok_c;
      bin     <= bin_wide[AW-1:0];
      history <= s_tdata[61:14];
      weight  <= s_tdata[85:62];
    end
  end

  // Walk counter shared by the post-reset clearing pass and the flush sweep.
  always_ff @(posedge clk) begin
    if (rst) begin
      walk <= '0;
    end else if (cmd.walk_zero) begin
      walk <= '0;
    end else if (cmd.walk_inc) begin
      walk <= walk + AW'(1);
    end
  end

  assign is_flush  = (kind == htally_pkg::KIND_FLUSH);
  assign bank_addr = (cmd.clr || is_flush) ? walk : bin;

  always_comb begin
    det_cmd.rd      = cmd.rd;
    det_cmd.eval    = cmd.eval;
    det_cmd.clr     = cmd.clr;
    det_cmd.flush   = is_flush;
    det_cmd.history = history;
    det_cmd.weight  = weight;
    det_cmd.wr      = cmd.wr && (is_flush || ((kind == htally_pkg::KIND_COUNT) && !sel_src));
    src_cmd         = det_cmd;
    src_cmd.wr      = cmd.wr && (is_flush || ((kind == htally_pkg::KIND_COUNT) && sel_src));
  end

  htally_bank #(.DEPTH(DEPTH), .AW(AW)) u_det (
    .clk   (clk),
    .cmd   (det_cmd),
    .addr  (bank_addr),
    .rdata (det_rdata)
  );

  htally_bank #(.DEPTH(DEPTH), .AW(AW)) u_src (
    .clk   (clk),
    .cmd   (src_cmd),
    .addr  (bank_addr),
    .rdata (src_rdata)
  );

  // Result of the current item: zero unless a valid read loads a bin.
  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      res_total   <= '0;
      res_squares <= '0;
      res_sat     <= 1'b0;
    end else if (cmd.eval && (kind == htally_pkg::KIND_READ)) begin
      res_total   <= sel_src ? src_rdata.total   : det_rdata.total;
      res_squares <= sel_src ? src_rdata.squares : det_rdata.squares;
      res_sat     <= sel_src ? src_rdata.sat     : det_rdata.sat;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (cmd.load_out) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load_out) begin
      m_tdata <= {res_squares, res_total};
      m_tuser <= res_sat;
    end
  end

  always_comb begin
    sts.kind      = kind;
    sts.bin_ok    = bin_ok;
    sts.walk_last = (walk == AW'(DEPTH - 1));
    sts.out_free  = !m_tvalid || m_tready;
  end

  `HTA_ASSERT_IMPL(a_count_one_bank, det_cmd.wr && src_cmd.wr, is_flush, "count wrote both banks")
  `HTA_ASSERT_NEXT(a_load_shows, cmd.load_out, m_tvalid, "loaded result not presented")

endmodule

/* rtl/htally_ctrl.sv */
// ----------------------------------------------------------------------------
// htally_ctrl
// Controller: clearing pass, item sequencing and flush sweep.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module htally_ctrl (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  in_valid,
  input  htally_pkg::ctrl_sts_t sts,
  output htally_pkg::ctrl_cmd_t cmd,
  output logic                  in_ready
);

  typedef enum logic [5:0] {
    S_CLEAR  = 6'b000001,
    S_IDLE   = 6'b000010,
    S_READ   = 6'b000100,
    S_EVAL   = 6'b001000,
    S_WRITE  = 6'b010000,
    S_FINISH = 6'b100000
  } state_t;

  state_t state;
  state_t state_next;
  logic   needs_bin;

  assign needs_bin = ((sts.kind == htally_pkg::KIND_COUNT) ||
                      (sts.kind == htally_pkg::KIND_READ)) && sts.bin_ok;

  always_comb begin
    state_next = state;
    cmd        = '0;
    in_ready   = 1'b0;
    unique case (state)
      S_CLEAR: begin
        cmd.clr = 1'b1;
        if (sts.walk_last) begin
          cmd.walk_zero = 1'b1;
          state_next    = S_IDLE;
        end else begin
          cmd.walk_inc = 1'b1;
        end
      end
      S_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd.capture = 1'b1;
          state_next  = S_READ;
        end
      end
      S_READ: begin
        if (needs_bin || (sts.kind == htally_pkg::KIND_FLUSH)) begin
          cmd.rd     = 1'b1;
          state_next = S_EVAL;
        end else begin
          state_next = S_FINISH;
        end
      end
      S_EVAL: begin
        cmd.eval   = 1'b1;
        state_next = (sts.kind == htally_pkg::KIND_READ) ? S_FINISH : S_WRITE;
      end
      S_WRITE: begin
        cmd.wr = 1'b1;
        if ((sts.kind == htally_pkg::KIND_FLUSH) && !sts.walk_last) begin
          cmd.walk_inc = 1'b1;
          state_next   = S_READ;
        end else begin
          cmd.walk_zero = 1'b1;
          state_next    = S_FINISH;
        end
      end
      S_FINISH: begin
        if (sts.out_free) begin
          cmd.load_out = 1'b1;
          state_next   = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_CLEAR;
    end else begin
      state <= state_next;
    end
  end

  `HTA_ASSERT_IMPL(a_eval_after_read, state == S_EVAL, $past(state) == S_READ, "eval without read")
  `HTA_ASSERT_IMPL(a_load_when_free, cmd.load_out, sts.out_free, "result overwritten")
  `HTA_ASSERT_NEXT(a_write_then, cmd.wr, state == S_READ || state == S_FINISH, "bad state after write")

endmodule

/* rtl/history_binned_tally_accumulator_unit.sv */
// The unit takes one item at a time: s_tready is high again only after the current
// item's result is loaded into the output register, which waits while that register is full.
// A flush sweeps every bin of both sets in turn, with a read, an evaluate and a write
// through one memory port for each bin, as a count has for its one bin.
// After reset the unit clears all NUM_PROJECTIONS*NUM_PIXELS bins of both memories, with
// s_tready low; a finished result may wait in the output register while the next item enters.
// ----------------------------------------------------------------------------
// history_binned_tally_accumulator_unit
// Per-bin Monte Carlo history-by-history tallies (detected and source sets).
// ----------------------------------------------------------------------------
//
// Each set holds one bin per (projection, pixel), bin = pixel + projection * NUM_PIXELS.
// A count adds its weight to the bin's pending per-history sum. When the count belongs
// to a newer history than the bin's mark, the pending sum is folded first: added to the
// total, and its square added to the sum of squares. All sums saturate and set the bin's
// sticky saturation flag. A flush folds every marked bin and clears its mark. A read
// returns the bin's total, sum of squares and saturation flag; every other item returns
// an all-zero result.
//
// The controller sequences each item as read, evaluate (squaring and the total add are
// registered) and write-back, a read without it. The datapath holds the two bank memories,
// the captured item, the walk counter used by both the clearing pass and the flush sweep,
// and the output register that decouples the result side from the input side.
module history_binned_tally_accumulator_unit #(
  parameter int NUM_PROJECTIONS = 64,
  parameter int NUM_PIXELS      = 256
) (
  input  logic         clk,
  input  logic         rst,
  input  logic         s_tvalid,
  output logic         s_tready,
  input  logic [87:0]  s_tdata,   // projection[5:0], pixel[13:6], history[61:14],
                                  // weight[85:62], zero pad[87:86]
  input  logic [2:0]   s_tuser,   // op[2:0]
  output logic         m_tvalid,
  input  logic         m_tready,
  output logic [111:0] m_tdata,   // total[47:0], total_squares[111:48]
  output logic [0:0]   m_tuser    // saturated[0]
);

  localparam int DEPTH = NUM_PROJECTIONS * NUM_PIXELS;
  localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;

  htally_pkg::ctrl_cmd_t cmd;
  htally_pkg::ctrl_sts_t sts;

  // The controller only ever sees status; it never touches the payload.
  htally_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (s_tvalid),
    .sts      (sts),
    .cmd      (cmd),
    .in_ready (s_tready)
  );

  htally_dp #(
    .NUM_PROJECTIONS (NUM_PROJECTIONS),
    .NUM_PIXELS      (NUM_PIXELS),
    .DEPTH           (DEPTH),
    .AW              (AW)
  ) u_dp (
    .clk      (clk),
    .rst      (rst),
    .cmd      (cmd),
    .sts      (sts),
    .s_tdata  (s_tdata),
    .s_tuser  (s_tuser),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser)
  );

endmodule
